// File: design/cossim_pkg.sv
`default_nettype none

package cossim_pkg;

  // Field and accumulator widths
  localparam int ElemW  = 16;
  localparam int AccW   = 48;
  localparam int WideW  = AccW + 1;
  localparam int RootW  = AccW / 2;
  localparam int SimW   = 16;

  // Iteration counts of the finishing sequence
  localparam int SqrtSteps = AccW / 2;
  localparam int DivSteps  = SimW;
  localparam int CntW      = $clog2(SqrtSteps);

  // First trial bit of the digit-by-digit square root: highest even power of two
  localparam logic [AccW-1:0] SqrtTop = AccW'(1) << (AccW - 2);

  // Q1.15 limits
  localparam logic [SimW-1:0] SimMax = {1'b0, {(SimW-1){1'b1}}};
  localparam logic [SimW-1:0] SimMin = {1'b1, {(SimW-1){1'b0}}};

  typedef logic signed [AccW-1:0] acc_t;

  // Finished sums handed from the accumulator to the finisher
  typedef struct packed {
    logic valid;
    acc_t dot;
    acc_t norm_a;
    acc_t norm_b;
  } totals_t;

  // One result item
  typedef struct packed {
    logic [SimW-1:0] similarity;
    logic            zero_norm;
  } result_t;

endpackage

`default_nettype wire

// File: design/cossim_sub.sv
`default_nettype none

// Shared compare-and-subtract unit: used by every root and divide step
module cossim_sub
  import cossim_pkg::*;
(
  input  wire logic [WideW-1:0] minuend,
  input  wire logic [WideW-1:0] subtrahend,
  output logic                  ge,
  output logic [WideW-1:0]      diff
);

  logic [WideW:0] full;

  // borrow out clear means minuend >= subtrahend
  assign full = {1'b0, minuend} - {1'b0, subtrahend};
  assign ge   = ~full[WideW];
  assign diff = full[WideW-1:0];

endmodule

`default_nettype wire

// File: design/cossim_acc.sv
`default_nettype none

// Saturating accumulation of dot product and both squared norms,
// one 16x16 signed multiplier shared over three steps per item
module cossim_acc
  import cossim_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [ElemW-1:0] elem_a,
  input  wire logic signed [ElemW-1:0] elem_b,
  input  wire logic                    last_pair,
  input  wire logic                    fin_ready,
  output logic                         busy,
  output totals_t                      totals
);

  typedef enum logic [2:0] {
    A_IDLE,
    A_AB,
    A_AA,
    A_BB,
    A_END,
    A_HAND
  } acc_state_t;

  acc_state_t                  state;
  logic signed [ElemW-1:0]     a_r;
  logic signed [ElemW-1:0]     b_r;
  logic                        last_r;
  logic signed [2*ElemW-1:0]   prod;
  acc_t                        dot;
  acc_t                        norm_a;
  acc_t                        norm_b;

  logic signed [ElemW-1:0]     op_x;
  logic signed [ElemW-1:0]     op_y;
  logic signed [2*ElemW-1:0]   product;

  // add with clamp to the signed accumulator range
  function automatic acc_t sat_add(input acc_t acc, input logic signed [2*ElemW-1:0] p);
    logic signed [AccW:0] s;
    acc_t                 r;
    s = {acc[AccW-1], acc} + {{(AccW+1-2*ElemW){p[2*ElemW-1]}}, p};
    if (s[AccW] != s[AccW-1]) begin
      r = s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = s[AccW-1:0];
    end
    return r;
  endfunction

  // operand select: a*b, then a*a, then b*b
  always_comb begin
    op_x = (state == A_BB) ? b_r : a_r;
    case (state)
      A_AB:    op_y = b_r;
      A_AA:    op_y = a_r;
      default: op_y = b_r;
    endcase
    product = op_x * op_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= A_IDLE;
      dot    <= '0;
      norm_a <= '0;
      norm_b <= '0;
    end else begin
      case (state)
        A_IDLE: begin
          if (start) begin
            a_r    <= elem_a;
            b_r    <= elem_b;
            last_r <= last_pair;
            state  <= A_AB;
          end
        end
        A_AB: begin
          prod  <= product;
          state <= A_AA;
        end
        A_AA: begin
          dot   <= sat_add(dot, prod);
          prod  <= product;
          state <= A_BB;
        end
        A_BB: begin
          norm_a <= sat_add(norm_a, prod);
          prod   <= product;
          state  <= A_END;
        end
        A_END: begin
          norm_b <= sat_add(norm_b, prod);
          state  <= last_r ? A_HAND : A_IDLE;
        end
        A_HAND: begin
          // once the finisher is ready it takes the sums in this cycle; start the next vector clean
          if (fin_ready) begin
            dot    <= '0;
            norm_a <= '0;
            norm_b <= '0;
            state  <= A_IDLE;
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

  assign busy          = (state != A_IDLE);
  assign totals.valid  = (state == A_HAND);
  assign totals.dot    = dot;
  assign totals.norm_a = norm_a;
  assign totals.norm_b = norm_b;

endmodule

`default_nettype wire

// File: design/cossim_fin.sv
`default_nettype none

// Finishing sequencer: two square roots, one multiply, range check and a
// restoring divide, root, check and divide steps on the shared compare-and-subtract unit
module cossim_fin
  import cossim_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire totals_t totals,
  input  wire logic    out_free,
  output logic         ready,
  output logic         res_valid,
  output result_t      result
);

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQA,
    F_SQB,
    F_MUL,
    F_CHK,
    F_DIV,
    F_DONE
  } fin_state_t;

  fin_state_t              state;
  logic [AccW-1:0]         x;
  logic [AccW-1:0]         root;
  logic [AccW-1:0]         sq_bit;
  logic [CntW-1:0]         cnt;
  logic [AccW-1:0]         nb_r;
  logic [RootW-1:0]        ra;
  logic [RootW-1:0]        rb;
  logic [AccW-1:0]         den;
  logic [AccW-1:0]         mag;
  logic                    neg;
  logic [AccW-1:0]         rem;
  logic [DivSteps-1:0]     quo;
  logic [SimW-1:0]         sim_r;
  logic                    zn_r;

  logic [WideW-1:0]        minu;
  logic [WideW-1:0]        subt;
  logic                    ge;
  logic [WideW-1:0]       diff;
  logic [AccW-1:0]         root_step;
  logic [DivSteps-1:0]     q_next;
  logic                    zero_in;

  // clamp the quotient magnitude to Q1.15 and apply the sign
  function automatic logic [SimW-1:0] clamp(input logic n, input logic ovf,
                                            input logic [DivSteps-1:0] q);
    logic [SimW-1:0] r;
    if (n) begin
      r = (ovf || q > SimMin) ? SimMin : (~q + 1'b1);
    end else begin
      r = (ovf || q > SimMax) ? SimMax : q;
    end
    return r;
  endfunction

  // operands for the shared unit
  always_comb begin
    case (state)
      F_SQA, F_SQB: begin
        minu = {1'b0, x};
        subt = {1'b0, root} + {1'b0, sq_bit};
      end
      F_CHK: begin
        // quotient of two or more: saturate without dividing
        minu = {1'b0, mag};
        subt = {den, 1'b0};
      end
      F_DIV: begin
        minu = (cnt == CntW'(DivSteps-1)) ? {1'b0, rem} : {rem, 1'b0};
        subt = {1'b0, den};
      end
      default: begin
        minu = '0;
        subt = '0;
      end
    endcase
  end

  cossim_sub u_sub (
    .minuend    (minu),
    .subtrahend (subt),
    .ge         (ge),
    .diff       (diff)
  );

  assign root_step = ge ? ((root >> 1) + sq_bit) : (root >> 1);
  assign q_next    = {quo[DivSteps-2:0], ge};
  assign zero_in   = (totals.norm_a == '0) || (totals.norm_b == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (totals.valid) begin
            x      <= totals.norm_a;
            nb_r   <= totals.norm_b;
            root   <= '0;
            sq_bit <= SqrtTop;
            cnt    <= CntW'(SqrtSteps-1);
            neg    <= totals.dot[AccW-1];
            mag    <= totals.dot[AccW-1] ? (~totals.dot + 1'b1) : totals.dot;
            if (zero_in) begin
              sim_r <= '0;
              zn_r  <= 1'b1;
              state <= F_DONE;
            end else begin
              zn_r  <= 1'b0;
              state <= F_SQA;
            end
          end
        end
        F_SQA, F_SQB: begin
          if (ge) begin
            x <= diff[AccW-1:0];
          end
          root   <= root_step;
          sq_bit <= sq_bit >> 2;
          cnt    <= cnt - 1'b1;
          if (cnt == '0) begin
            if (state == F_SQA) begin
              // first root done, start on the second norm
              ra     <= root_step[RootW-1:0];
              x      <= nb_r;
              root   <= '0;
              sq_bit <= SqrtTop;
              cnt    <= CntW'(SqrtSteps-1);
              state  <= F_SQB;
            end else begin
              rb    <= root_step[RootW-1:0];
              state <= F_MUL;
            end
          end
        end
        F_MUL: begin
          den   <= ra * rb;
          state <= F_CHK;
        end
        F_CHK: begin
          if (ge) begin
            sim_r <= clamp(neg, 1'b1, '0);
            state <= F_DONE;
          end else begin
            rem   <= mag;
            quo   <= '0;
            cnt   <= CntW'(DivSteps-1);
            state <= F_DIV;
          end
        end
        F_DIV: begin
          rem <= ge ? diff[AccW-1:0] : minu[AccW-1:0];
          quo <= q_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            sim_r <= clamp(neg, 1'b0, q_next);
            state <= F_DONE;
          end
        end
        F_DONE: begin
          if (out_free) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign ready             = (state == F_IDLE);
  assign res_valid         = (state == F_DONE) && out_free;
  assign result.similarity = sim_r;
  assign result.zero_norm  = zn_r;

endmodule

`default_nettype wire

// File: design/cosine_similarity.sv
`default_nettype none

// Channel  Handshake               Payload
// pair     pair_valid, pair_stall  elem_a, elem_b, last_pair
// sim      sim_valid, sim_stall    similarity, zero_norm
//
// Each pair is accepted, then gets three products on one shared 16x16 multiplier
// and the last accumulate; a last pair then waits for the finisher. The finisher
// runs load, 24 + 24 root steps, multiply, range check, 16 divide steps and
// output per vector, skips the divide when the ratio is two or more, goes from
// load to output for a zero norm, and overlaps the next vector. Reset (rst,
// synchronous) clears the sums and empties the output register; a stalled
// result holds in the output register and holds the finisher.
module cosine_similarity
  import cossim_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    pair_valid,
  output logic                         pair_stall,
  input  wire logic signed [ElemW-1:0] elem_a,
  input  wire logic signed [ElemW-1:0] elem_b,
  input  wire logic                    last_pair,
  output logic                         sim_valid,
  input  wire logic                    sim_stall,
  output logic signed [SimW-1:0]       similarity,
  output logic                         zero_norm
);

  logic    acc_busy;
  logic    fin_ready;
  logic    res_valid;
  logic    out_free;
  totals_t totals;
  result_t result;

  assign pair_stall = acc_busy;
  assign out_free   = ~sim_valid | ~sim_stall;

  cossim_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .start     (pair_valid & ~acc_busy),
    .elem_a    (elem_a),
    .elem_b    (elem_b),
    .last_pair (last_pair),
    .fin_ready (fin_ready),
    .busy      (acc_busy),
    .totals    (totals)
  );

  cossim_fin u_fin (
    .clk       (clk),
    .rst       (rst),
    .totals    (totals),
    .out_free  (out_free),
    .ready     (fin_ready),
    .res_valid (res_valid),
    .result    (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sim_valid <= 1'b0;
    end else if (res_valid) begin
      sim_valid  <= 1'b1;
      similarity <= result.similarity;
      zero_norm  <= result.zero_norm;
    end else if (!sim_stall) begin
      sim_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
